// ===== src/hss_pkg.sv =====
`timescale 1ns / 1ps

package hss_pkg;

    localparam int MOTORS_DEF = 16;
    localparam int MOTOR_W    = 4;
    localparam int COIL_W     = 4;
    localparam int CYCLE_W    = 24;
    localparam int TICK_W     = 16;
    localparam int BACK_W     = 8;
    localparam int MASK_W     = 16;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // full steps per motor revolution, in eight-phase cycles
    localparam int CYCLES_PER_ROUND = 50;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_MOVE = 2'd1,
        MODE_BACK = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READY_MASK  = 2'd0,
        CFG_PHASE_TICKS = 2'd1,
        CFG_BACK_CYCLES = 2'd2
    } cfg_index_t;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_TICK  = 1'b1
    } req_t;

    typedef struct packed {
        logic [MASK_W-1:0] ready_mask;
        logic [TICK_W-1:0] phase_ticks;
        logic [BACK_W-1:0] back_cycles;
    } cfg_t;

    typedef struct packed {
        logic               req_type;
        logic [MOTOR_W-1:0] motor_id;
        logic               direction;
        logic [CYCLE_W-1:0] cycle_count;
        logic               limit_left;
        logic               limit_right;
    } item_t;

    typedef struct packed {
        logic [COIL_W-1:0]  coil_bits;
        logic [MOTOR_W-1:0] motor_sel;
        logic               dir_now;
        mode_t              run_mode;
        logic [PHASE_W-1:0] phase_index;
        logic [CYCLE_W-1:0] cycles_left;
        logic [TICK_W-1:0]  hold_count;
    } state_t;

    typedef struct packed {
        logic [COIL_W-1:0]  coils;
        logic [MOTOR_W-1:0] active_motor;
        logic               busy_res;
        logic               accepted;
        logic               done_res;
        logic               limit_stop;
    } result_t;

    // coil bit set by each half-step phase, forward and reverse
    function automatic logic [COIL_W-1:0] phase_set(input logic dir,
                                                   input logic [PHASE_W-1:0] p);
        logic [COIL_W-1:0] s;
        s = '0;
        case (p)
            3'd0:    s = 4'h1;
            3'd1:    s = dir ? 4'h8 : 4'h4;
            3'd3:    s = 4'h2;
            3'd5:    s = dir ? 4'h4 : 4'h8;
            3'd7:    s = 4'h1;
            default: s = 4'h0;
        endcase
        return s;
    endfunction

    // coil bit cleared by each half-step phase
    function automatic logic [COIL_W-1:0] phase_clr(input logic dir,
                                                   input logic [PHASE_W-1:0] p);
        logic [COIL_W-1:0] c;
        c = '0;
        case (p)
            3'd0:    c = dir ? 4'h4 : 4'h8;
            3'd2:    c = 4'h1;
            3'd4:    c = dir ? 4'h8 : 4'h4;
            3'd6:    c = 4'h2;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

endpackage

// ===== src/hss_cfg.sv =====
`timescale 1ns / 1ps

module hss_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0]   cfg_data,
    output hss_pkg::cfg_t                    cfg
);

    hss_pkg::cfg_t cfg_reg;
    hss_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                hss_pkg::CFG_READY_MASK:  cfg_next.ready_mask  = cfg_data;
                hss_pkg::CFG_PHASE_TICKS: cfg_next.phase_ticks = cfg_data;
                hss_pkg::CFG_BACK_CYCLES:
                    cfg_next.back_cycles = cfg_data[hss_pkg::BACK_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ready_mask  <= '0;
            cfg_reg.phase_ticks <= hss_pkg::TICK_W'(1);
            cfg_reg.back_cycles <= hss_pkg::BACK_W'(4);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/hss_step.sv =====
`timescale 1ns / 1ps

module hss_step
#(
    parameter int MOTORS = hss_pkg::MOTORS_DEF
)
(
    input  hss_pkg::cfg_t    cfg,
    input  hss_pkg::state_t  state,
    input  hss_pkg::item_t   item,
    output hss_pkg::state_t  state_next,
    output hss_pkg::result_t result
);

    logic acc;
    logic done;
    logic lstop;
    logic apply;
    logic lim_hit;
    logic id_ok;
    logic [hss_pkg::COIL_W-1:0] set_bits;
    logic [hss_pkg::COIL_W-1:0] clr_bits;

    assign id_ok   = {1'b0, item.motor_id} < (hss_pkg::MOTOR_W+1)'(MOTORS);
    assign lim_hit = state.dir_now ? item.limit_right : item.limit_left;

    always_comb
    begin
        state_next = state;
        acc        = 1'b0;
        done       = 1'b0;
        lstop      = 1'b0;
        apply      = 1'b0;
        set_bits   = '0;
        clr_bits   = '0;

        if (item.req_type == hss_pkg::REQ_START)
        begin
            if (state.run_mode == hss_pkg::MODE_IDLE && id_ok &&
                cfg.ready_mask[item.motor_id])
            begin
                acc                    = 1'b1;
                state_next.motor_sel   = item.motor_id;
                state_next.dir_now     = item.direction;
                state_next.coil_bits   = '0;
                state_next.phase_index = '0;
                state_next.hold_count  = '0;
                state_next.cycles_left = item.cycle_count;
                state_next.run_mode    = hss_pkg::MODE_MOVE;
                if (item.cycle_count == '0)
                begin
                    state_next.run_mode = hss_pkg::MODE_IDLE;
                    done                = 1'b1;
                end
            end
        end
        else if (state.run_mode != hss_pkg::MODE_IDLE)
        begin
            if (state.hold_count != '0)
            begin
                state_next.hold_count = state.hold_count - 1'b1;
            end
            else
            begin
                apply = 1'b1;
                if (state.phase_index == '0)
                begin
                    if (state.cycles_left == '0)
                    begin
                        // all cycles run: finish
                        lstop = (state.run_mode == hss_pkg::MODE_BACK);
                        done  = 1'b1;
                        apply = 1'b0;
                    end
                    else if (state.run_mode == hss_pkg::MODE_MOVE && lim_hit)
                    begin
                        // limit seen: back off with the other table
                        state_next.run_mode    = hss_pkg::MODE_BACK;
                        state_next.dir_now     = ~state.dir_now;
                        state_next.cycles_left =
                            hss_pkg::CYCLE_W'(cfg.back_cycles) - 1'b1;
                        if (cfg.back_cycles == '0)
                        begin
                            lstop = 1'b1;
                            done  = 1'b1;
                            apply = 1'b0;
                        end
                    end
                    else
                    begin
                        state_next.cycles_left = state.cycles_left - 1'b1;
                    end
                end
                if (apply)
                begin
                    set_bits = hss_pkg::phase_set(state_next.dir_now, state.phase_index);
                    clr_bits = hss_pkg::phase_clr(state_next.dir_now, state.phase_index);
                    state_next.coil_bits   = (state.coil_bits & ~clr_bits) | set_bits;
                    state_next.phase_index = state.phase_index + 1'b1;
                    state_next.hold_count  = (cfg.phase_ticks == '0) ? '0 :
                                             cfg.phase_ticks - 1'b1;
                end
            end
        end

        if (done)
        begin
            state_next.coil_bits   = '0;
            state_next.run_mode    = hss_pkg::MODE_IDLE;
            state_next.phase_index = '0;
            state_next.cycles_left = '0;
            state_next.hold_count  = '0;
        end

        result.coils        = state_next.coil_bits;
        result.active_motor = state_next.motor_sel;
        result.busy_res     = (state_next.run_mode != hss_pkg::MODE_IDLE);
        result.accepted     = acc;
        result.done_res     = done;
        result.limit_stop   = lstop;
    end

endmodule

// ===== src/half_step_stepper_sequencer.sv =====
`timescale 1ns / 1ps
// half-step stepper sequencer: one start or tick transaction per clock while in_stall is low
// each transaction is captured in the input register, and its result is held in the result register
// throughput: one transaction per cycle unless a full result slot is stalled; the state updates as each one advances
// reset (rst_n, async, active low): idle, coil state low, motor 0, phase_ticks 1,
// back_cycles 4, no motor ready; no clearing pass is needed

module half_step_stepper_sequencer
#(
    parameter int MOTORS = hss_pkg::MOTORS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic [hss_pkg::MOTOR_W-1:0]        motor_id,
    input  logic                               direction,
    input  logic [hss_pkg::CYCLE_W-1:0]        cycle_count,
    input  logic                               limit_left,
    input  logic                               limit_right,

    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [hss_pkg::COIL_W-1:0]         coils,
    output logic [hss_pkg::MOTOR_W-1:0]        active_motor,
    output logic                               busy_res,
    output logic                               accepted,
    output logic                               done_res,
    output logic                               limit_stop,

    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0]     cfg_data
);

    hss_pkg::cfg_t    cfg;

    // input register: one captured transaction waiting for the step logic
    logic             in_vld_reg;
    logic             in_vld_next;
    hss_pkg::item_t   item_reg;

    // sequencer state, updated when the captured transaction is processed
    hss_pkg::state_t  state_reg;
    hss_pkg::state_t  state_next;

    // result register, holds while the consumer stalls
    logic             out_vld_reg;
    logic             out_vld_next;
    hss_pkg::result_t res_reg;
    hss_pkg::result_t step_res;

    logic             advance;
    logic             in_take;

    hss_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hss_step
    #(
        .MOTORS (MOTORS)
    )
    u_step
    (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    // the captured transaction moves on unless the result slot is full and stalled
    assign advance  = in_vld_reg && !(out_vld_reg && out_stall);
    assign in_stall = in_vld_reg && out_vld_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '{coil_bits:   '0,
                             motor_sel:   '0,
                             dir_now:     1'b0,
                             run_mode:    hss_pkg::MODE_IDLE,
                             phase_index: '0,
                             cycles_left: '0,
                             hold_count:  '0};
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= '{req_type:    req_type,
                          motor_id:    motor_id,
                          direction:   direction,
                          cycle_count: cycle_count,
                          limit_left:  limit_left,
                          limit_right: limit_right};
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid    = out_vld_reg;
    assign coils        = res_reg.coils;
    assign active_motor = res_reg.active_motor;
    assign busy_res     = res_reg.busy_res;
    assign accepted     = res_reg.accepted;
    assign done_res     = res_reg.done_res;
    assign limit_stop   = res_reg.limit_stop;

endmodule

// ===== verif/tb_half_step_stepper_sequencer.sv =====
`timescale 1ns / 1ps

module tb_half_step_stepper_sequencer;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PERCENT  = 21;
    // result passes the input and result registers after its transaction, keep some margin
    localparam int SETTLE_CYCLES = 4;
    // cycles in a row with no transaction on any channel before giving up
    localparam int STALL_LIMIT   = 5000;
    localparam int PRINT_LIMIT   = 50;

    // predicts the coil drive word for every accepted command or tick and
    // checks the block's result transactions against it in order
    class stepper_scoreboard;
        // register copies
        logic [hss_pkg::MASK_W-1:0]  ready_mask;
        logic [hss_pkg::TICK_W-1:0]  ticks_per_phase;
        logic [hss_pkg::BACK_W-1:0]  backoff_cycles;
        // sequencer state
        logic [hss_pkg::COIL_W-1:0]  coil_q;
        logic [hss_pkg::MOTOR_W-1:0] motor_q;
        logic                        rev_q;
        hss_pkg::mode_t              mode_q;
        logic [hss_pkg::PHASE_W-1:0] phase_q;
        logic [hss_pkg::CYCLE_W-1:0] cycles_q;
        logic [hss_pkg::TICK_W-1:0]  hold_q;
        // half-step tables, indexed by phase
        logic [hss_pkg::COIL_W-1:0]  fwd_on[8];
        logic [hss_pkg::COIL_W-1:0]  fwd_off[8];
        logic [hss_pkg::COIL_W-1:0]  rev_on[8];
        logic [hss_pkg::COIL_W-1:0]  rev_off[8];
        hss_pkg::result_t            pending_drive[$];
        int                          errors;

        function new();
            fwd_on  = '{4'h1, 4'h4, 4'h0, 4'h2, 4'h0, 4'h8, 4'h0, 4'h1};
            fwd_off = '{4'h8, 4'h0, 4'h1, 4'h0, 4'h4, 4'h0, 4'h2, 4'h0};
            rev_on  = '{4'h1, 4'h8, 4'h0, 4'h2, 4'h0, 4'h4, 4'h0, 4'h1};
            rev_off = '{4'h4, 4'h0, 4'h1, 4'h0, 4'h8, 4'h0, 4'h2, 4'h0};
            ready_mask      = '0;
            ticks_per_phase = 16'd1;
            backoff_cycles  = 8'd4;
            coil_q   = '0;
            motor_q  = '0;
            rev_q    = 1'b0;
            mode_q   = hss_pkg::MODE_IDLE;
            phase_q  = '0;
            cycles_q = '0;
            hold_q   = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [hss_pkg::CFG_IDX_W-1:0] idx,
                                logic [hss_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                hss_pkg::CFG_READY_MASK:  ready_mask      = data;
                hss_pkg::CFG_PHASE_TICKS: ticks_per_phase = data;
                hss_pkg::CFG_BACK_CYCLES: backoff_cycles  = data[hss_pkg::BACK_W-1:0];
                default: ;
            endcase
        endfunction

        function void stop_motion();
            coil_q   = '0;
            mode_q   = hss_pkg::MODE_IDLE;
            phase_q  = '0;
            cycles_q = '0;
            hold_q   = '0;
        endfunction

        function void take_command(hss_pkg::item_t cmd);
            hss_pkg::result_t r;
            logic             step_now;
            logic             hit;
            r = '0;
            if (cmd.req_type == hss_pkg::REQ_START)
            begin
                if (mode_q == hss_pkg::MODE_IDLE && ready_mask[cmd.motor_id])
                begin
                    r.accepted = 1'b1;
                    motor_q  = cmd.motor_id;
                    rev_q    = cmd.direction;
                    coil_q   = '0;
                    phase_q  = '0;
                    hold_q   = '0;
                    cycles_q = cmd.cycle_count;
                    mode_q   = hss_pkg::MODE_MOVE;
                    if (cmd.cycle_count == '0)
                    begin
                        stop_motion();
                        r.done_res = 1'b1;
                    end
                end
            end
            else if (mode_q != hss_pkg::MODE_IDLE)
            begin
                if (hold_q != '0)
                begin
                    hold_q = hold_q - 1'b1;
                end
                else
                begin
                    step_now = 1'b1;
                    if (phase_q == '0)
                    begin
                        hit = rev_q ? cmd.limit_right : cmd.limit_left;
                        if (cycles_q == '0)
                        begin
                            r.limit_stop = (mode_q == hss_pkg::MODE_BACK);
                            r.done_res   = 1'b1;
                            stop_motion();
                            step_now = 1'b0;
                        end
                        else if (mode_q == hss_pkg::MODE_MOVE && hit)
                        begin
                            mode_q   = hss_pkg::MODE_BACK;
                            rev_q    = ~rev_q;
                            cycles_q = hss_pkg::CYCLE_W'(backoff_cycles);
                            if (cycles_q == '0)
                            begin
                                r.limit_stop = 1'b1;
                                r.done_res   = 1'b1;
                                stop_motion();
                                step_now = 1'b0;
                            end
                        end
                        if (step_now)
                            cycles_q = cycles_q - 1'b1;
                    end
                    if (step_now)
                    begin
                        if (rev_q)
                            coil_q = (coil_q & ~rev_off[phase_q]) | rev_on[phase_q];
                        else
                            coil_q = (coil_q & ~fwd_off[phase_q]) | fwd_on[phase_q];
                        phase_q = phase_q + 1'b1;
                        hold_q  = (ticks_per_phase == '0) ? '0 : ticks_per_phase - 1'b1;
                    end
                end
            end
            r.coils        = coil_q;
            r.active_motor = motor_q;
            r.busy_res     = (mode_q != hss_pkg::MODE_IDLE);
            pending_drive.push_back(r);
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT)
                $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0h wanted %0h", name, got, want));
        endtask

        task check_drive(hss_pkg::result_t got);
            hss_pkg::result_t want;
            if (pending_drive.size() == 0)
            begin
                report("result transaction with nothing outstanding");
            end
            else
            begin
                want = pending_drive.pop_front();
                compare_field("coils", got.coils, want.coils);
                compare_field("active_motor", got.active_motor, want.active_motor);
                compare_field("busy_res", got.busy_res, want.busy_res);
                compare_field("accepted", got.accepted, want.accepted);
                compare_field("done_res", got.done_res, want.done_res);
                compare_field("limit_stop", got.limit_stop, want.limit_stop);
            end
        endtask
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input channel
    logic                          in_valid    = 1'b0;
    logic                          in_stall;
    logic                          req_type    = 1'b0;
    logic [hss_pkg::MOTOR_W-1:0]   motor_id    = '0;
    logic                          direction   = 1'b0;
    logic [hss_pkg::CYCLE_W-1:0]   cycle_count = '0;
    logic                          limit_left  = 1'b0;
    logic                          limit_right = 1'b0;

    // result channel
    logic                          out_valid;
    logic                          out_stall   = 1'b0;
    logic [hss_pkg::COIL_W-1:0]    coils;
    logic [hss_pkg::MOTOR_W-1:0]   active_motor;
    logic                          busy_res;
    logic                          accepted;
    logic                          done_res;
    logic                          limit_stop;

    // register write channel
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [hss_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [hss_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

    // random idling on both channels, switched off for one whole phase
    logic                          idling_on   = 1'b1;
    int                            quiet_cycles = 0;
    hss_pkg::item_t                seen_cmd;
    hss_pkg::result_t              seen_drive;

    stepper_scoreboard model = new();

    half_step_stepper_sequencer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .motor_id     (motor_id),
        .direction    (direction),
        .cycle_count  (cycle_count),
        .limit_left   (limit_left),
        .limit_right  (limit_right),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coils        (coils),
        .active_motor (active_motor),
        .busy_res     (busy_res),
        .accepted     (accepted),
        .done_res     (done_res),
        .limit_stop   (limit_stop),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // receiver back-pressure, changed only on the falling edge
    always @(negedge clk)
    begin
        out_stall <= idling_on && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // sample every channel on the rising edge: register writes and commands
    // feed the predictor, result transactions are checked against it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                model.write_reg(cfg_index, cfg_data);
            if (out_valid && !out_stall)
            begin
                seen_drive.coils        = coils;
                seen_drive.active_motor = active_motor;
                seen_drive.busy_res     = busy_res;
                seen_drive.accepted     = accepted;
                seen_drive.done_res     = done_res;
                seen_drive.limit_stop   = limit_stop;
                model.check_drive(seen_drive);
            end
            if (in_valid && !in_stall)
            begin
                seen_cmd.req_type    = req_type;
                seen_cmd.motor_id    = motor_id;
                seen_cmd.direction   = direction;
                seen_cmd.cycle_count = cycle_count;
                seen_cmd.limit_left  = limit_left;
                seen_cmd.limit_right = limit_right;
                model.take_command(seen_cmd);
            end
        end
    end

    // watchdog: a long run of cycles with no transaction anywhere means a hang
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // every driving task starts and ends on a falling edge; send leaves valid
    // high, so between back-to-back transactions only random idling drops it
    task automatic send(input logic rq, input logic [hss_pkg::MOTOR_W-1:0] mid,
                        input logic dir, input logic [hss_pkg::CYCLE_W-1:0] cnt,
                        input logic ll, input logic lr);
        while (idling_on && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= rq;
        motor_id    <= mid;
        direction   <= dir;
        cycle_count <= cnt;
        limit_left  <= ll;
        limit_right <= lr;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // tick with random filler in the start-only fields
    task automatic tick(input logic ll, input logic lr);
        send(hss_pkg::REQ_TICK, hss_pkg::MOTOR_W'($urandom_range(0, 15)),
             1'($urandom_range(0, 1)), hss_pkg::CYCLE_W'($urandom_range(0, 24'hFFFFFF)),
             ll, lr);
    endtask

    // hold the sender until every outstanding result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (model.pending_drive.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input hss_pkg::cfg_index_t idx,
                             input logic [hss_pkg::CFG_DATA_W-1:0] data);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // registers only change with nothing in flight
    task automatic set_config(input logic [hss_pkg::MASK_W-1:0] mask,
                              input logic [hss_pkg::TICK_W-1:0] ticks,
                              input logic [hss_pkg::BACK_W-1:0] back);
        drain_results();
        write_reg(hss_pkg::CFG_READY_MASK, mask);
        write_reg(hss_pkg::CFG_PHASE_TICKS, ticks);
        write_reg(hss_pkg::CFG_BACK_CYCLES, hss_pkg::CFG_DATA_W'(back));
    endtask

    // mostly well-formed moves: a start on a ready motor when idle, otherwise
    // ticks with the odd limit hit; the rest is raw random transactions
    task automatic run_phase(input logic [hss_pkg::MASK_W-1:0] mask,
                             input logic [hss_pkg::TICK_W-1:0] ticks,
                             input logic [hss_pkg::BACK_W-1:0] back, input int n_items,
                             input logic quiet, input logic pause_midway);
        logic [hss_pkg::MOTOR_W-1:0] mid;
        set_config(mask, ticks, back);
        idling_on <= !quiet;
        for (int k = 0; k < n_items; k++)
        begin
            if (pause_midway && k == n_items / 2)
                drain_results();
            if ($urandom_range(0, 99) < 80)
            begin
                if (model.mode_q == hss_pkg::MODE_IDLE)
                begin
                    do
                        mid = hss_pkg::MOTOR_W'($urandom_range(0, 15));
                    while (mask != '0 && !mask[mid]);
                    send(hss_pkg::REQ_START, mid, 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 9) == 0) ? '0 :
                         hss_pkg::CYCLE_W'($urandom_range(1, 3)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    tick($urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
                end
            end
            else
            begin
                send(1'($urandom_range(0, 1)), hss_pkg::MOTOR_W'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)),
                     hss_pkg::CYCLE_W'($urandom_range(0, 24'hFFFFFF)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        // run out whatever is still moving; both limits high ends it quickly
        while (model.mode_q != hss_pkg::MODE_IDLE)
            tick(1'b1, 1'b1);
        idling_on <= 1'b1;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: no motor ready, so the start is turned away
        send(hss_pkg::REQ_START, 4'd0, 1'b0, 24'd1, 1'b0, 1'b0);
        // tick while idle does nothing
        tick(1'b1, 1'b1);

        // zero phase_ticks acts as one, zero back-off ends on the limit tick
        set_config(16'hFFFF, 16'd0, 8'd0);
        // zero cycles: done at once
        send(hss_pkg::REQ_START, 4'd15, 1'b1, 24'd0, 1'b0, 1'b0);
        // limits on a start are ignored
        send(hss_pkg::REQ_START, 4'd3, 1'b0, 24'hFFFFFF, 1'b1, 1'b1);
        // busy: rejected
        send(hss_pkg::REQ_START, 4'd4, 1'b1, 24'd5, 1'b0, 1'b0);
        tick(1'b0, 1'b0);
        repeat (7) tick(1'b1, 1'b1);                            // limits only matter between cycles
        tick(1'b1, 1'b0);                                       // left limit, no back-off

        // reverse move hits the right limit, one forward back-off cycle
        set_config(16'h8001, 16'd1, 8'd1);
        send(hss_pkg::REQ_START, 4'd1, 1'b0, 24'd1, 1'b0, 1'b0);    // motor not ready
        send(hss_pkg::REQ_START, 4'd15, 1'b1, 24'd2, 1'b0, 1'b0);
        repeat (8) tick(1'b0, 1'b0);
        tick(1'b0, 1'b1);
        repeat (8) tick(1'b1, 1'b1);                            // not checked during back-off
        // plain forward cycle that runs to its count
        send(hss_pkg::REQ_START, 4'd0, 1'b0, 24'd1, 1'b0, 1'b0);
        repeat (9) tick(1'b0, 1'b0);

        run_phase(16'hFFFF, 16'd1, 8'd2, 120, 1'b1, 1'b0);
        run_phase(16'($urandom_range(0, 65535)) | 16'h0001, 16'd3, 8'd0, 120, 1'b0, 1'b1);
        run_phase(16'h5A5A, 16'd1, 8'd7, 120, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'd2, 8'd1, 120, 1'b0, 1'b1);
        run_phase(16'($urandom_range(0, 65535)) | 16'h8000, 16'd1, 8'd4, 120, 1'b0, 1'b0);

        // longest hold last, the move never gets past its first phase
        set_config(16'hFFFF, 16'hFFFF, 8'd3);
        send(hss_pkg::REQ_START, 4'd7, 1'b0, 24'd3, 1'b0, 1'b0);
        repeat (10) tick(1'b0, 1'b0);

        drain_results();
        if (model.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== half_step_stepper_sequencer.f =====
src/hss_pkg.sv
src/hss_cfg.sv
src/hss_step.sv
src/half_step_stepper_sequencer.sv
verif/tb_half_step_stepper_sequencer.sv
